// ===== rtl/core/tdpt_pkg.sv =====
`default_nettype none

package tdpt_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned OUT_TDATA_W    = 8;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
  } tdpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic sq_over;
    logic div_last;
    logic rem_zero;
  } tdpt_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/tdpt_dp.sv =====
`default_nettype none

module tdpt_dp #(
  parameter int unsigned DATA_WIDTH = tdpt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic [DATA_WIDTH-1:0]   number,
  input  wire tdpt_pkg::tdpt_cmd_t     cmd,
  output tdpt_pkg::tdpt_status_t       status
);
  import tdpt_pkg::*;

  localparam int unsigned SQ_W  = DATA_WIDTH + 1;
  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] n_r,   n_nxt;
  logic [DATA_WIDTH-1:0] d_r,   d_nxt;
  logic [SQ_W-1:0]       sq_r,  sq_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] q_r,   q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH:0]   rem_shift;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  neg;

  // one restoring step of the remainder
  assign rem_shift = {rem_r, q_r[DATA_WIDTH-1]};
  assign rem_sub   = rem_shift - {1'b0, d_r};
  assign neg       = n_r[DATA_WIDTH-1];

  always_comb begin
    n_nxt   = n_r;
    d_nxt   = d_r;
    sq_nxt  = sq_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      n_nxt  = number;
      d_nxt  = DATA_WIDTH'(3);
      sq_nxt = SQ_W'(9);
    end
    if (cmd.div_start) begin
      rem_nxt = '0;
      q_nxt   = n_r;
      cnt_nxt = CNT_W'(DATA_WIDTH);
    end
    if (cmd.div_step) begin
      if (rem_shift >= {1'b0, d_r}) begin
        rem_nxt = rem_sub[DATA_WIDTH-1:0];
      end else begin
        rem_nxt = rem_shift[DATA_WIDTH-1:0];
      end
      q_nxt   = {q_r[DATA_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      d_nxt  = d_r + DATA_WIDTH'(2);
      sq_nxt = sq_r + SQ_W'({d_r, 2'b00}) + SQ_W'(4);
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    status.trivial       = neg || (n_r < DATA_WIDTH'(4)) || !n_r[0];
    status.trivial_prime = !neg && ((n_r == DATA_WIDTH'(2)) || (n_r == DATA_WIDTH'(3)));
    status.sq_over       = sq_r > {1'b0, n_r};
    status.div_last      = cnt_r == CNT_W'(1);
    status.rem_zero      = rem_r == '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tdpt_ctrl.sv =====
`default_nettype none

module tdpt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic                       is_prime,
  input  wire tdpt_pkg::tdpt_status_t status,
  output tdpt_pkg::tdpt_cmd_t        cmd
);
  import tdpt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLASS = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       res_r, res_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       oprime_r, oprime_nxt;

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = ovalid_r;
  assign is_prime   = oprime_r;

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    ovalid_nxt = ovalid_r && !out_tready;
    oprime_nxt = oprime_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (status.trivial) begin
          res_nxt   = status.trivial_prime;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.sq_over) begin
          res_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status.rem_zero) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cmd.next_div = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oprime_nxt = res_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    res_r    <= res_nxt;
    oprime_r <= oprime_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/trial_division_prime_test.sv =====
`default_nettype none

// Trial-division prime test. Each input item carries one two's-complement
// number of DATA_WIDTH bits in the low bits of in_tdata; each gives exactly one
// result item whose bit 0 is 1 when the number is prime. Values of 1 or less,
// negatives included, are not prime, two and three are prime, and other even
// values are not. Odd values are tried against odd divisors 3, 5, 7, ...
// while the divisor squared does not exceed the number; the square is kept
// by an adder (no multiplier) one bit wider than the data, so it never
// overflows. Each divisor takes a bound check, a pass through the bit-serial
// restoring remainder unit (one quotient bit per cycle) and an evaluate
// state, and trivial values skip the divisors. One item is worked on at a
// time; the result sits in an output register, so a stalled output holds
// back only the next result, not the start of the next item.
module trial_division_prime_test #(
  parameter int unsigned DATA_WIDTH = tdpt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     in_tdata,   // number
  // result channel
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [tdpt_pkg::OUT_TDATA_W-1:0]         out_tdata   // is_prime
);
  import tdpt_pkg::*;

  tdpt_cmd_t    cmd;
  tdpt_status_t status;
  logic         is_prime;

  // bits above the data width are ignored
  tdpt_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk    (clk),
    .number (in_tdata[DATA_WIDTH-1:0]),
    .cmd    (cmd),
    .status (status)
  );

  tdpt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .is_prime   (is_prime),
    .status     (status),
    .cmd        (cmd)
  );

  // zero padding up to a whole byte
  assign out_tdata = {{(OUT_TDATA_W-1){1'b0}}, is_prime};

endmodule

`default_nettype wire
